/* rtl/p2v_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package p2v_pkg;

  // filter_mode codes
  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_IIR = 2'd1;
  localparam logic [1:0] MODE_AVG = 2'd2;

  // register indexes on the config port
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_BW   = 2'd1;
  localparam logic [1:0] REG_WLEN = 2'd2;

  // register reset values
  localparam logic [1:0]  MODE_RST = MODE_IIR;
  localparam logic [31:0] BW_RST   = 32'd200000;
  localparam logic [3:0]  WLEN_RST = 4'd5;

  // microseconds per second
  localparam logic [31:0] US_PER_S = 32'd1000000;

  // what the shared divider is working on
  typedef enum logic [1:0] {
    OP_LIN  = 2'd0,
    OP_IIR  = 2'd1,
    OP_MEAN = 2'd2
  } div_op_t;

  // sequencer states
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CHK    = 13'b0000000000010,
    S_MUL1   = 13'b0000000000100,
    S_MUL2   = 13'b0000000001000,
    S_DSTART = 13'b0000000010000,
    S_DWAIT  = 13'b0000000100000,
    S_EVCHK  = 13'b0000001000000,
    S_EVRD   = 13'b0000010000000,
    S_EVSUB  = 13'b0000100000000,
    S_RWR    = 13'b0001000000000,
    S_OSEL   = 13'b0010000000000,
    S_MEANLD = 13'b0100000000000,
    S_RAWOUT = 13'b1000000000000
  } state_t;

endpackage

`default_nettype wire

/* rtl/position_to_velocity_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Position-to-velocity filter. Each input beat (timestamp in us, x/y/z position
// in Q16.16 m) yields one output beat with the x/y/z velocity in Q16.16 m/s,
// saturated, chosen by filter_mode: raw difference, first-order IIR with
// alpha = dt/(bandwidth_time_us+dt), or a mean of the last window_len raw
// velocities. The first beat after reset outputs zero and sets first_sample;
// a repeated timestamp sets zero_interval and repeats the current output.
// One item is processed at a time: s_tready is high only while idle. All
// quotients come from one shared restoring divider that produces one bit per
// cycle over COORD_BITS+33 bits. An item takes six divisions (a raw one and
// an IIR one per axis), plus the EVCHK, EVRD and EVSUB states for each
// evicted ring entry, and three more divisions in moving-average mode. A
// repeated timestamp skips the multiplies and the raw and IIR divisions and
// goes straight to output selection. A seeding beat goes straight to the
// output register. A finished result sits in the output register, so the next
// item is accepted while it waits.
module position_to_velocity_filter_unit #(
  parameter int MAX_WINDOW = 8,
  parameter int COORD_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // config write port
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  // input beat
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // tdata: time_us, pos_x, pos_y, pos_z
  input  wire logic [((32+3*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // output beat
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // tdata: vel_x, vel_y, vel_z
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // tuser: first_sample, zero_interval
  output logic [1:0]               m_tuser
);

  localparam int C    = COORD_BITS;
  localparam int W    = MAX_WINDOW;
  localparam int AW   = (W > 1) ? $clog2(W) : 1;
  localparam int CW   = $clog2(W + 1);
  localparam int TW   = C + $clog2(W) + 1;
  localparam int PW   = C + 33;
  localparam int DVW  = 33;
  localparam int OUTW = ((3*C+7)/8)*8;

  localparam logic [PW-1:0] QMAX  = {{(PW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic [PW-1:0] QMINM = PW'(1) << (C-1);

  // ---------------- helpers ----------------
  function automatic logic [C:0] mag1(input logic signed [C:0] v);
    mag1 = v[C] ? (C+1)'(-v) : (C+1)'(v);
  endfunction

  // signed saturation of a quotient magnitude to C bits
  function automatic logic signed [C-1:0] sat_q(input logic [PW-1:0] q, input logic neg);
    if (!neg) begin
      sat_q = (q > QMAX) ? {1'b0, {(C-1){1'b1}}} : q[C-1:0];
    end else begin
      sat_q = (q > QMINM) ? {1'b1, {(C-1){1'b0}}} : C'(-q[C-1:0]);
    end
  endfunction

  // saturate a (C+3)-bit signed sum to C bits
  function automatic logic signed [C-1:0] sat_s(input logic signed [C+2:0] v);
    if ((&v[C+2:C-1]) || !(|v[C+2:C-1])) begin
      sat_s = v[C-1:0];
    end else begin
      sat_s = v[C+2] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    end
  endfunction

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    wrap = (s >= (CW+1)'(W)) ? AW'(s - (CW+1)'(W)) : AW'(s);
  endfunction

  // ---------------- config registers ----------------
  logic [1:0]  filter_mode;
  logic [31:0] bandwidth_time_us;
  logic [3:0]  window_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode       <= p2v_pkg::MODE_RST;
      bandwidth_time_us <= p2v_pkg::BW_RST;
      window_len        <= p2v_pkg::WLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        p2v_pkg::REG_MODE: filter_mode       <= cfg_data[1:0];
        p2v_pkg::REG_BW:   bandwidth_time_us <= cfg_data;
        p2v_pkg::REG_WLEN: window_len        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 1..W
  logic [7:0]    wl8;
  logic [CW-1:0] len;
  assign wl8 = {4'b0000, window_len};
  always_comb begin
    if (wl8 == 8'd0) begin
      len = CW'(1);
    end else if (wl8 > 8'(W)) begin
      len = CW'(W);
    end else begin
      len = CW'(wl8);
    end
  end

  // ---------------- state ----------------
  p2v_pkg::state_t  state;
  p2v_pkg::div_op_t op;
  logic [1:0]       ax;

  logic                seeded;
  logic [31:0]         prev_time;
  logic signed [C-1:0] prev_pos [3];
  logic signed [C-1:0] prev_vel [3];
  logic signed [C-1:0] lin      [3];
  logic signed [C-1:0] res      [3];
  logic signed [TW-1:0] total   [3];
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;

  logic [31:0]         t_r;
  logic signed [C-1:0] pos_r [3];
  logic                first_r;
  logic                zero_r;
  logic                neg;
  logic [PW-1:0]       prod;

  // ---------------- combinational datapath ----------------
  logic [31:0]         dt;
  logic [DVW-1:0]      den;
  logic signed [C:0]   diff;
  logic signed [C:0]   delta;
  logic [C:0]          mul_a;
  logic [31:0]         mul_b;
  logic [PW-1:0]       mul_p;
  logic [TW-1:0]       tot_mag;
  logic signed [C+2:0] iir_sum;

  assign dt    = t_r - prev_time;
  assign den   = {1'b0, bandwidth_time_us} + {1'b0, dt};
  assign diff  = (C+1)'(pos_r[ax]) - (C+1)'(prev_pos[ax]);
  assign delta = (C+1)'(lin[ax]) - (C+1)'(prev_vel[ax]);
  assign tot_mag = total[ax][TW-1] ? TW'(-total[ax]) : TW'(total[ax]);

  // shared multiplier, registered into prod
  assign mul_a = (state == p2v_pkg::S_MUL1) ? mag1(diff) : mag1(delta);
  assign mul_b = (state == p2v_pkg::S_MUL1) ? p2v_pkg::US_PER_S : dt;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // shared divider
  logic           div_start;
  logic [DVW-1:0] div_den;
  logic           div_done;
  logic [PW-1:0]  div_q;

  assign div_start = (state == p2v_pkg::S_DSTART);
  always_comb begin
    unique case (op)
      p2v_pkg::OP_LIN:  div_den = {1'b0, dt};
      p2v_pkg::OP_IIR:  div_den = den;
      p2v_pkg::OP_MEAN: div_den = DVW'(count);
      default:          div_den = {1'b0, dt};
    endcase
  end

  p2v_div #(.NW(PW), .DW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign iir_sum = (C+3)'(prev_vel[ax]) +
                   (neg ? (C+3)'(-$signed({3'b000, div_q[C-1:0]}))
                        : (C+3)'($signed({3'b000, div_q[C-1:0]})));

  // ring memory
  logic             ring_we;
  logic [AW-1:0]    ring_waddr;
  logic [3*C-1:0]   ring_wdata;
  logic [AW-1:0]    ring_raddr;
  logic [3*C-1:0]   ring_rdata;
  logic signed [C-1:0] rd_v [3];

  logic accept;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == p2v_pkg::S_IDLE);

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = '0;
    ring_wdata = '0;
    if (accept && !seeded) begin
      ring_we = 1'b1;
    end else if (state == p2v_pkg::S_RWR) begin
      ring_we    = 1'b1;
      ring_waddr = wrap({1'b0, CW'(head)} + {1'b0, count});
      ring_wdata = {lin[2], lin[1], lin[0]};
    end
  end

  assign ring_raddr = (state == p2v_pkg::S_EVRD) ? head
                    : wrap({1'b0, CW'(head)} + {1'b0, count} - (CW+1)'(1));

  p2v_ring #(.DEPTH(W), .DW(3*C), .AW(AW)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_v[k] = ring_rdata[k*C +: C];
    end
  end

  // ---------------- sequencer ----------------
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= p2v_pkg::S_IDLE;
      op        <= p2v_pkg::OP_LIN;
      ax        <= '0;
      seeded    <= 1'b0;
      prev_time <= '0;
      head      <= '0;
      count     <= '0;
      first_r   <= 1'b0;
      zero_r    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_pos[k] <= '0;
        prev_vel[k] <= '0;
        total[k]    <= '0;
        res[k]      <= '0;
      end
    end else begin
      unique case (state)
        p2v_pkg::S_IDLE: begin
          if (accept) begin
            t_r <= s_tdata[31:0];
            for (int k = 0; k < 3; k++) begin
              pos_r[k] <= s_tdata[32 + k*C +: C];
            end
            ax <= '0;
            if (!seeded) begin
              // seeding beat: store reference, one zero in the ring
              seeded    <= 1'b1;
              prev_time <= s_tdata[31:0];
              head      <= '0;
              count     <= CW'(1);
              first_r   <= 1'b1;
              zero_r    <= 1'b0;
              for (int k = 0; k < 3; k++) begin
                prev_pos[k] <= s_tdata[32 + k*C +: C];
                prev_vel[k] <= '0;
                total[k]    <= '0;
                res[k]      <= '0;
              end
              state <= p2v_pkg::S_RAWOUT;
            end else begin
              first_r <= 1'b0;
              state   <= p2v_pkg::S_CHK;
            end
          end
        end

        p2v_pkg::S_CHK: begin
          zero_r <= (dt == 32'd0);
          state  <= (dt == 32'd0) ? p2v_pkg::S_OSEL : p2v_pkg::S_MUL1;
        end

        // |dp| * 1e6, then / dt
        p2v_pkg::S_MUL1: begin
          neg   <= diff[C];
          prod  <= mul_p;
          op    <= p2v_pkg::OP_LIN;
          state <= p2v_pkg::S_DSTART;
        end

        // |lin - v| * dt, then / (bw + dt)
        p2v_pkg::S_MUL2: begin
          neg   <= delta[C];
          prod  <= mul_p;
          op    <= p2v_pkg::OP_IIR;
          state <= p2v_pkg::S_DSTART;
        end

        p2v_pkg::S_MEANLD: begin
          neg   <= total[ax][TW-1];
          prod  <= PW'(tot_mag);
          op    <= p2v_pkg::OP_MEAN;
          state <= p2v_pkg::S_DSTART;
        end

        p2v_pkg::S_DSTART: state <= p2v_pkg::S_DWAIT;

        p2v_pkg::S_DWAIT: begin
          if (div_done) begin
            unique case (op)
              p2v_pkg::OP_LIN: begin
                lin[ax] <= sat_q(div_q, neg);
                state   <= p2v_pkg::S_MUL2;
              end
              p2v_pkg::OP_IIR: begin
                prev_vel[ax] <= sat_s(iir_sum);
                prev_pos[ax] <= pos_r[ax];
                if (ax == 2'd2) begin
                  prev_time <= t_r;
                  state     <= p2v_pkg::S_EVCHK;
                end else begin
                  ax    <= ax + 2'd1;
                  state <= p2v_pkg::S_MUL1;
                end
              end
              default: begin
                res[ax] <= neg ? C'(-div_q[C-1:0]) : div_q[C-1:0];
                if (ax == 2'd2) begin
                  state <= p2v_pkg::S_RAWOUT;
                end else begin
                  ax    <= ax + 2'd1;
                  state <= p2v_pkg::S_MEANLD;
                end
              end
            endcase
          end
        end

        // evict oldest entries until the new one fits
        p2v_pkg::S_EVCHK: begin
          state <= (count >= len) ? p2v_pkg::S_EVRD : p2v_pkg::S_RWR;
        end

        p2v_pkg::S_EVRD: state <= p2v_pkg::S_EVSUB;

        p2v_pkg::S_EVSUB: begin
          for (int k = 0; k < 3; k++) begin
            total[k] <= total[k] - $signed({{(TW-C){rd_v[k][C-1]}}, rd_v[k]});
          end
          head  <= (head == AW'(W-1)) ? '0 : head + AW'(1);
          count <= count - CW'(1);
          state <= p2v_pkg::S_EVCHK;
        end

        p2v_pkg::S_RWR: begin
          for (int k = 0; k < 3; k++) begin
            total[k] <= total[k] + $signed({{(TW-C){lin[k][C-1]}}, lin[k]});
          end
          count <= count + CW'(1);
          state <= p2v_pkg::S_OSEL;
        end

        // pick the output of the selected mode
        p2v_pkg::S_OSEL: begin
          ax <= '0;
          priority if (filter_mode == p2v_pkg::MODE_IIR) begin
            for (int k = 0; k < 3; k++) begin
              res[k] <= prev_vel[k];
            end
            state <= p2v_pkg::S_RAWOUT;
            first_r <= 1'b0;
          end else if (filter_mode == p2v_pkg::MODE_AVG) begin
            state <= p2v_pkg::S_MEANLD;
          end else begin
            // raw: newest ring entry, read issued this cycle
            op    <= p2v_pkg::OP_LIN;
            state <= p2v_pkg::S_RAWOUT;
            first_r <= 1'b0;
          end
        end

        // hand the result to the output register
        p2v_pkg::S_RAWOUT: begin
          if (out_free) begin
            state <= p2v_pkg::S_IDLE;
          end
        end

        default: state <= p2v_pkg::S_IDLE;
      endcase
    end
  end

  // raw mode takes ring data; flag marks the pending raw pick
  logic raw_pick;
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_pick <= 1'b0;
    end else if (state == p2v_pkg::S_OSEL) begin
      raw_pick <= (filter_mode != p2v_pkg::MODE_IIR) && (filter_mode != p2v_pkg::MODE_AVG);
    end else if (state == p2v_pkg::S_IDLE) begin
      raw_pick <= 1'b0;
    end
  end

  // ---------------- output register ----------------
  logic signed [C-1:0] vel [3];
  logic                out_first;
  logic                out_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == p2v_pkg::S_RAWOUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == p2v_pkg::S_RAWOUT && out_free) begin
      for (int k = 0; k < 3; k++) begin
        vel[k] <= raw_pick ? rd_v[k] : res[k];
      end
      out_first <= first_r;
      out_zero  <= zero_r;
    end
  end

  assign m_tdata = OUTW'({vel[2], vel[1], vel[0]});
  assign m_tuser = {out_zero, out_first};

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(W))
    else $error("ring count above window depth");

  a_seeded_count: assert property (@(posedge clk) disable iff (rst)
    (seeded && state == p2v_pkg::S_IDLE) |-> (count != '0))
    else $error("seeded ring is empty");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == p2v_pkg::S_DWAIT))
    else $error("divider finished outside wait state");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("ready right after accepting a beat");

endmodule

`default_nettype wire

/* rtl/p2v_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module p2v_div #(
  parameter int NW = 65,
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dv;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     rem_sh;
  logic            fits;

  // shift in next dividend bit, trial subtract
  assign rem_sh   = {rem, q[NW-1]};
  assign fits     = rem_sh >= {1'b0, dv};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      q   <= {q[NW-2:0], fits};
      rem <= fits ? DW'(rem_sh - {1'b0, dv}) : DW'(rem_sh);
    end
  end

endmodule

`default_nettype wire

/* rtl/p2v_ring.sv */
`timescale 1ns / 1ps
`default_nettype none

// Velocity ring storage: one write, one registered read per cycle.
module p2v_ring #(
  parameter int DEPTH = 8,
  parameter int DW    = 96,
  parameter int AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
